// ===== hdl/v3au_pkg.sv =====
// Package with widths, op codes, pipeline structs and helpers for the vector ALU.
package v3au_pkg;

  localparam int DW    = 32;
  localparam int FB    = 16;
  localparam int OPW   = 4;
  localparam int MW    = DW + 1;
  localparam int PW    = 2 * MW;
  localparam int WW    = PW + 2;
  localparam int RootW = WW / 2;
  localparam int RemW  = RootW + 2;
  localparam int QW    = FB + 1;

  typedef enum logic [OPW-1:0] {
    OP_ADD    = 0,
    OP_SUB    = 1,
    OP_MUL    = 2,
    OP_SCALE  = 3,
    OP_DOT    = 4,
    OP_CROSS  = 5,
    OP_LENGTH = 6,
    OP_NORM   = 7,
    OP_LERP   = 8,
    OP_MIN    = 9,
    OP_MAX    = 10,
    OP_DIST   = 11,
    OP_MULADD = 12
  } op_e;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic  flag;
    word_t val;
  } sat_t;

  typedef struct packed {
    op_e              op;
    logic [2:0][DW-1:0] r;
    logic [DW-1:0]    rs;
    logic             sat;
  } pay_t;

  typedef struct packed {
    logic             v;
    pay_t             pay;
    logic [WW-1:0]    rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic                  v;
    pay_t                  pay;
    logic [RootW-1:0]      len;
    logic [2:0][RootW-1:0] rem;
    logic [2:0][QW-1:0]    qn;
  } dv_t;

  typedef struct packed {
    logic signed [WW-1:0] w;
    word_t                r;
    logic                 sat;
  } lane_t;

  function automatic logic signed [MW-1:0] ext(input word_t x);
    return {x[DW-1], x};
  endfunction

  function automatic sat_t sat_fn(input logic signed [WW-1:0] v);
    sat_t                 s;
    logic signed [WW-1:0] lo_ext;
    lo_ext = $signed(v[DW-1:0]);
    if (lo_ext == v) begin
      s.flag = 1'b0;
      s.val  = v[DW-1:0];
    end else begin
      s.flag = 1'b1;
      s.val  = v[WW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== hdl/v3au_lane.sv =====
// One vector lane: operand selection, two multipliers and the per-component result.
module v3au_lane (
  input  logic             clk_i,
  input  logic             en_i,
  input  v3au_pkg::op_e    op_i,
  input  v3au_pkg::word_t  a_i,
  input  v3au_pkg::word_t  b_i,
  input  v3au_pkg::word_t  t_i,
  input  v3au_pkg::word_t  ca0_i,
  input  v3au_pkg::word_t  cb0_i,
  input  v3au_pkg::word_t  ca1_i,
  input  v3au_pkg::word_t  cb1_i,
  output v3au_pkg::lane_t  lane_o
);

  logic signed [v3au_pkg::MW-1:0] d, ma0, mb0, ma1, mb1;
  logic signed [v3au_pkg::PW-1:0] p0_d, p1_d, p0_q, p1_q;
  v3au_pkg::op_e                  op_q;
  v3au_pkg::word_t                a_q, b_q;
  logic signed [v3au_pkg::WW-1:0] w, fl, aw, bw;
  v3au_pkg::sat_t                 s;
  v3au_pkg::lane_t                lane_d, lane_q;

  always_comb begin
    d   = v3au_pkg::ext(b_i) - v3au_pkg::ext(a_i);
    ma0 = '0;
    mb0 = '0;
    ma1 = '0;
    mb1 = '0;
    case (op_i)
      v3au_pkg::OP_MUL, v3au_pkg::OP_DOT: begin
        ma0 = v3au_pkg::ext(a_i);
        mb0 = v3au_pkg::ext(b_i);
      end
      v3au_pkg::OP_SCALE: begin
        ma0 = v3au_pkg::ext(a_i);
        mb0 = v3au_pkg::ext(t_i);
      end
      v3au_pkg::OP_CROSS: begin
        ma0 = v3au_pkg::ext(ca0_i);
        mb0 = v3au_pkg::ext(cb0_i);
        ma1 = v3au_pkg::ext(ca1_i);
        mb1 = v3au_pkg::ext(cb1_i);
      end
      v3au_pkg::OP_LENGTH, v3au_pkg::OP_NORM: begin
        ma0 = v3au_pkg::ext(a_i);
        mb0 = v3au_pkg::ext(a_i);
      end
      v3au_pkg::OP_DIST: begin
        ma0 = d;
        mb0 = d;
      end
      v3au_pkg::OP_LERP: begin
        ma0 = d;
        mb0 = v3au_pkg::ext(t_i);
      end
      v3au_pkg::OP_MULADD: begin
        ma0 = v3au_pkg::ext(b_i);
        mb0 = v3au_pkg::ext(t_i);
      end
      default: begin
      end
    endcase
    p0_d = ma0 * mb0;
    p1_d = ma1 * mb1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_i;
      a_q  <= a_i;
      b_q  <= b_i;
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
  end

  always_comb begin
    w  = {{2{p0_q[v3au_pkg::PW-1]}}, p0_q} - {{2{p1_q[v3au_pkg::PW-1]}}, p1_q};
    fl = w >>> v3au_pkg::FB;
    aw = a_q;
    bw = b_q;
    s  = '0;
    lane_d.w   = w;
    lane_d.r   = '0;
    lane_d.sat = 1'b0;
    case (op_q)
      v3au_pkg::OP_ADD:                                      s = v3au_pkg::sat_fn(aw + bw);
      v3au_pkg::OP_SUB:                                      s = v3au_pkg::sat_fn(aw - bw);
      v3au_pkg::OP_MUL, v3au_pkg::OP_SCALE, v3au_pkg::OP_CROSS: s = v3au_pkg::sat_fn(fl);
      v3au_pkg::OP_LERP, v3au_pkg::OP_MULADD:                s = v3au_pkg::sat_fn(aw + fl);
      v3au_pkg::OP_MIN:  s.val = (a_q < b_q) ? a_q : b_q;
      v3au_pkg::OP_MAX:  s.val = (a_q > b_q) ? a_q : b_q;
      v3au_pkg::OP_NORM: s.val = a_q;
      default: begin
      end
    endcase
    lane_d.r   = s.val;
    lane_d.sat = s.flag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== hdl/v3au_sqrt_step.sv =====
// One registered step of the pipelined floor square root, one root bit per step.
module v3au_sqrt_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  v3au_pkg::sq_t sq_i,
  output v3au_pkg::sq_t sq_o
);

  logic [v3au_pkg::RemW-1:0] bring, trial;
  logic                      ge;
  logic                      v_q;
  v3au_pkg::sq_t             dat_d, dat_q;

  always_comb begin
    bring = {sq_i.rem[v3au_pkg::RemW-3:0], sq_i.rad[v3au_pkg::WW-1:v3au_pkg::WW-2]};
    trial = {{(v3au_pkg::RemW-v3au_pkg::RootW-1){1'b0}},
             sq_i.root[v3au_pkg::RootW-2:0], 2'b01};
    ge    = (bring >= trial);
    dat_d      = sq_i;
    dat_d.rem  = ge ? (bring - trial) : bring;
    dat_d.root = {sq_i.root[v3au_pkg::RootW-2:0], ge};
    dat_d.rad  = {sq_i.rad[v3au_pkg::WW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= sq_i.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  always_comb begin
    sq_o   = dat_q;
    sq_o.v = v_q;
  end

endmodule

// ===== hdl/v3au_div_step.sv =====
// One registered restoring division step for the three normalize lanes.
module v3au_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  v3au_pkg::dv_t dv_i,
  output v3au_pkg::dv_t dv_o
);

  logic [2:0][v3au_pkg::RootW:0] r2, diff;
  logic [2:0]                    ge;
  logic                          v_q;
  v3au_pkg::dv_t                 dat_d, dat_q;

  always_comb begin
    dat_d = dv_i;
    for (int i = 0; i < 3; i++) begin
      r2[i]   = {dv_i.rem[i], dv_i.qn[i][v3au_pkg::QW-1]};
      diff[i] = r2[i] - {1'b0, dv_i.len};
      ge[i]   = (r2[i] >= {1'b0, dv_i.len});
      dat_d.rem[i] = ge[i] ? diff[i][v3au_pkg::RootW-1:0] : r2[i][v3au_pkg::RootW-1:0];
      dat_d.qn[i]  = {dv_i.qn[i][v3au_pkg::QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= dv_i.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  always_comb begin
    dv_o   = dat_q;
    dv_o.v = v_q;
  end

endmodule

// ===== hdl/vec3_arithmetic_unit.sv =====
// Top level of the three-component fixed-point vector ALU.
// Every op passes through 2 lane stages, 1 merge stage, 34 square root
// steps (one root bit each), 1 setup stage, 17 division steps and the output register.
// Throughput is one transaction per cycle; the whole pipeline stalls only when the
// output register is full and not taken.
// Reset clears all valid bits asynchronously; the datapath registers are not reset.
module vec3_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [223:0] s_axis_tdata_i,  // a_x, a_y, a_z, b_x, b_y, b_z, t
  input  logic [3:0]   s_axis_tuser_i,  // op
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,  // r_x, r_y, r_z, r_scalar
  output logic [0:0]   m_axis_tuser_o   // saturated
);

  localparam int DW = v3au_pkg::DW;

  logic                          en;
  v3au_pkg::op_e                 op_in, op2_q, op3_q;
  v3au_pkg::word_t [2:0]         a, b;
  v3au_pkg::word_t               t;
  v3au_pkg::lane_t [2:0]         lane;
  logic                          v2_q, v3_q;
  v3au_pkg::sq_t                 sq [v3au_pkg::RootW+1];
  v3au_pkg::dv_t                 dv [v3au_pkg::QW+1];
  v3au_pkg::sq_t                 sq0_d, sq0_q;
  v3au_pkg::dv_t                 dv0_d, dv0_q;
  logic                          sq0_v_q, dv0_v_q;
  logic signed [v3au_pkg::WW-1:0] sum, rootw;
  v3au_pkg::sat_t                dot_s, len_s;
  logic [DW-1:0]                 mg;
  v3au_pkg::pay_t                out_d, out_q, fin;
  logic [DW-1:0]                 qe;
  logic                          out_v_q;

  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign op_in           = v3au_pkg::op_e'(s_axis_tuser_i);
  assign t               = s_axis_tdata_i[7*DW-1:6*DW];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign a[i] = s_axis_tdata_i[(i+1)*DW-1:i*DW];
    assign b[i] = s_axis_tdata_i[(i+4)*DW-1:(i+3)*DW];
    v3au_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .op_i   (op_in),
      .a_i    (a[i]),
      .b_i    (b[i]),
      .t_i    (t),
      .ca0_i  (a[(i+1)%3]),
      .cb0_i  (b[(i+2)%3]),
      .ca1_i  (a[(i+2)%3]),
      .cb1_i  (b[(i+1)%3]),
      .lane_o (lane[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v2_q <= s_axis_tvalid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q <= op_in;
      op3_q <= op2_q;
    end
  end

  always_comb begin
    sum   = lane[0].w + lane[1].w + lane[2].w;
    dot_s = v3au_pkg::sat_fn(sum >>> v3au_pkg::FB);
    sq0_d = '0;
    sq0_d.v       = v3_q;
    sq0_d.pay.op  = op3_q;
    sq0_d.pay.sat = lane[0].sat | lane[1].sat | lane[2].sat;
    for (int i = 0; i < 3; i++) begin
      sq0_d.pay.r[i] = lane[i].r;
    end
    case (op3_q)
      v3au_pkg::OP_DOT: begin
        sq0_d.pay.rs  = dot_s.val;
        sq0_d.pay.sat = dot_s.flag;
      end
      v3au_pkg::OP_LENGTH, v3au_pkg::OP_NORM, v3au_pkg::OP_DIST: begin
        sq0_d.rad = sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq0_v_q <= 1'b0;
    end else if (en) begin
      sq0_v_q <= sq0_d.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq0_q <= sq0_d;
    end
  end

  always_comb begin
    sq[0]   = sq0_q;
    sq[0].v = sq0_v_q;
  end

  for (genvar k = 0; k < v3au_pkg::RootW; k++) begin : g_sqrt
    v3au_sqrt_step u_sqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sq_i   (sq[k]),
      .sq_o   (sq[k+1])
    );
  end

  always_comb begin
    rootw = {{(v3au_pkg::WW-v3au_pkg::RootW){1'b0}}, sq[v3au_pkg::RootW].root};
    len_s = v3au_pkg::sat_fn(rootw);
    dv0_d = '0;
    dv0_d.v   = sq[v3au_pkg::RootW].v;
    dv0_d.pay = sq[v3au_pkg::RootW].pay;
    dv0_d.len = sq[v3au_pkg::RootW].root;
    mg = '0;
    case (sq[v3au_pkg::RootW].pay.op)
      v3au_pkg::OP_LENGTH, v3au_pkg::OP_NORM, v3au_pkg::OP_DIST: begin
        dv0_d.pay.rs  = len_s.val;
        dv0_d.pay.sat = len_s.flag;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      mg = sq[v3au_pkg::RootW].pay.r[i][DW-1] ? (~sq[v3au_pkg::RootW].pay.r[i] + 1'b1)
                                              : sq[v3au_pkg::RootW].pay.r[i];
      dv0_d.rem[i] = {{(v3au_pkg::RootW-DW+1){1'b0}}, mg[DW-1:1]};
      dv0_d.qn[i]  = {mg[0], {v3au_pkg::FB{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_v_q <= 1'b0;
    end else if (en) begin
      dv0_v_q <= dv0_d.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv0_q <= dv0_d;
    end
  end

  always_comb begin
    dv[0]   = dv0_q;
    dv[0].v = dv0_v_q;
  end

  for (genvar k = 0; k < v3au_pkg::QW; k++) begin : g_div
    v3au_div_step u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .dv_i   (dv[k]),
      .dv_o   (dv[k+1])
    );
  end

  always_comb begin
    fin   = dv[v3au_pkg::QW].pay;
    out_d = fin;
    qe    = '0;
    if (fin.op == v3au_pkg::OP_NORM) begin
      for (int i = 0; i < 3; i++) begin
        qe = {{(DW-v3au_pkg::QW){1'b0}}, dv[v3au_pkg::QW].qn[i]};
        if (dv[v3au_pkg::QW].len == '0) begin
          out_d.r[i] = '0;
        end else begin
          out_d.r[i] = fin.r[i][DW-1] ? (~qe + 1'b1) : qe;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv[v3au_pkg::QW].v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.rs, out_q.r[2], out_q.r[1], out_q.r[0]};
  assign m_axis_tuser_o  = out_q.sat;

endmodule
